/* design/dense_layer_forward_core_defines.svh */
// Assertion helpers used by the asserting RTL file dense_layer_forward_core.sv.
`ifndef DENSE_LAYER_FORWARD_CORE_DEFINES_SVH
`define DENSE_LAYER_FORWARD_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DLF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlf assertion failed");
// next-cycle implication
`define DLF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlf assertion failed");
`else
`define DLF_ASSERT_SAME(lbl, ante, cons)
`define DLF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/dlf_pkg.sv */
package dlf_pkg;

  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = 40;
  localparam int RND_W  = ACC_W - 8;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 4;

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_BIAS    = 2'd1,
    OP_FEATURE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [0:0] CFG_IN_USED  = 1'b0;
  localparam logic [0:0] CFG_OUT_USED = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIAS,
    S_MAC,
    S_DRAIN,
    S_RND,
    S_SAT
  } state_t;

  typedef struct packed {
    logic init;       // load accumulator with the bias term
    logic opd_valid;  // feature/weight operands valid this cycle
  } mac_ctl_t;

endpackage

/* design/dlf_mac.sv */
module dlf_mac import dlf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] bias,
  input  logic signed [DATA_W-1:0] feat,
  input  logic signed [DATA_W-1:0] weight,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     busy
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.opd_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= feat * weight;
    if (ctl.init) begin
      // bias is Q8.8, accumulator is Q.16
      acc_r <= {{(ACC_W-DATA_W-8){bias[DATA_W-1]}}, bias, 8'd0};
    end else if (prod_vld_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign acc  = acc_r;
  assign busy = prod_vld_r;

endmodule

/* design/dense_layer_forward_core.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_op, in_row_index, in_col_index, in_value
// out      out_valid / out_ready  out_value, out_index, out_last, out_saturated
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Loads, non-final features and ignored items are accepted while idle.
// The final feature of a row starts the row; the single multiply-accumulate
// unit computes each output in turn, walking one weight per cycle.
// in_ready is low while a row is in progress; cfg_ready is always high.
// A stalled output holds the next result in the saturate step until taken.
// Reset clears control only; weight, bias and feature stores need writing.
`include "dense_layer_forward_core_defines.svh"

module dense_layer_forward_core import dlf_pkg::*; #(
  parameter int MAX_IN  = 16,
  parameter int MAX_OUT = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic [IDX_W-1:0]         in_row_index,
  input  logic [IDX_W-1:0]         in_col_index,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic [IDX_W-1:0]         out_index,
  output logic                     out_last,
  output logic                     out_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [CNT_W-1:0]         cfg_data
);

  // indices are 4 bits wide, so at most 16 rows/columns are reachable
  localparam int NI = (MAX_IN > 16) ? 16 : MAX_IN;
  localparam int NO = (MAX_OUT > 16) ? 16 : MAX_OUT;
  localparam int FW = (NI > 1) ? $clog2(NI) : 1;
  localparam int OW = (NO > 1) ? $clog2(NO) : 1;
  localparam int WD = NI * NO;
  localparam int AW = (WD > 1) ? $clog2(WD) : 1;

  logic signed [DATA_W-1:0] wmem [WD];
  logic signed [DATA_W-1:0] bias_mem [NO];
  logic signed [DATA_W-1:0] feat_mem [NI];

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  in_used_r, out_used_r;
  logic [CNT_W-1:0]  n_in, n_out;

  logic                     opd_vld_r;
  logic signed [DATA_W-1:0] wdata_r;
  logic signed [DATA_W-1:0] fdata_r;
  logic signed [RND_W-1:0]  rnd_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [IDX_W-1:0]         out_index_r;
  logic                     out_last_r;
  logic                     out_sat_r;

  logic                     in_xfer;
  logic                     w_we, b_we, f_we, row_start;
  logic [9:0]               w_addr_full, r_addr_full;
  logic                     out_load;
  logic signed [DATA_W-1:0] sat_value;
  logic                     sat_flag;

  mac_ctl_t                 mac_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic                     mac_busy;

  // effective counts: 0 acts as 1, clipped to store size
  always_comb begin
    if (in_used_r == '0) begin
      n_in = CNT_W'(1);
    end else if (in_used_r > CNT_W'(NI)) begin
      n_in = CNT_W'(NI);
    end else begin
      n_in = in_used_r;
    end
    if (out_used_r == '0) begin
      n_out = CNT_W'(1);
    end else if (out_used_r > CNT_W'(NO)) begin
      n_out = CNT_W'(NO);
    end else begin
      n_out = out_used_r;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_used_r  <= CNT_W'(16);
      out_used_r <= CNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IN_USED:  in_used_r  <= cfg_data;
        CFG_OUT_USED: out_used_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input decode
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    w_we      = 1'b0;
    b_we      = 1'b0;
    f_we      = 1'b0;
    row_start = 1'b0;
    if (in_xfer) begin
      unique case (op_t'(in_op))
        OP_WEIGHT: begin
          w_we = ({1'b0, in_row_index} < CNT_W'(NI)) && ({1'b0, in_col_index} < CNT_W'(NO));
        end
        OP_BIAS: begin
          b_we = ({1'b0, in_col_index} < CNT_W'(NO));
        end
        OP_FEATURE: begin
          f_we      = ({1'b0, in_row_index} < n_in);
          row_start = ({1'b0, in_row_index} == n_in - CNT_W'(1));
        end
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  assign w_addr_full = {6'd0, in_row_index} * 10'(NO) + {6'd0, in_col_index};
  assign r_addr_full = {6'd0, i_r} * 10'(NO) + {6'd0, j_r};

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_addr_full[AW-1:0]] <= in_value;
    end
    wdata_r <= wmem[r_addr_full[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bias_mem[in_col_index[OW-1:0]] <= in_value;
    end
    if (f_we) begin
      feat_mem[in_row_index[FW-1:0]] <= in_value;
    end
    fdata_r <= feat_mem[i_r[FW-1:0]];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    out_load  = 1'b0;
    mac_ctl   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (row_start) begin
          j_nxt     = '0;
          state_nxt = S_BIAS;
        end
      end
      S_BIAS: begin
        mac_ctl.init = 1'b1;
        i_nxt        = '0;
        state_nxt    = S_MAC;
      end
      S_MAC: begin
        if ({1'b0, i_r} == n_in - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!opd_vld_r && !mac_busy) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if ({1'b0, j_r} == n_out - CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_BIAS;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    mac_ctl.opd_valid = opd_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      i_r       <= '0;
      j_r       <= '0;
      opd_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      opd_vld_r <= (state_r == S_MAC);
    end
  end

  dlf_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .bias   (bias_mem[j_r[OW-1:0]]),
    .feat   (fdata_r),
    .weight (wdata_r),
    .acc    (acc),
    .busy   (mac_busy)
  );

  // round to nearest, ties up: floor((acc + 128) / 256)
  assign acc_rnd = acc + ACC_W'(128);

  always_ff @(posedge clk) begin
    rnd_r <= acc_rnd[ACC_W-1:8];
  end

  always_comb begin
    sat_flag = 1'b0;
    if (rnd_r > RND_W'(32767)) begin
      sat_value = 16'sh7fff;
      sat_flag  = 1'b1;
    end else if (rnd_r < -RND_W'(32768)) begin
      sat_value = -16'sh8000;
      sat_flag  = 1'b1;
    end else begin
      sat_value = rnd_r[DATA_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= sat_value;
      out_index_r <= j_r;
      out_last_r  <= ({1'b0, j_r} == n_out - CNT_W'(1));
      out_sat_r   <= sat_flag;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_index     = out_index_r;
  assign out_last      = out_last_r;
  assign out_saturated = out_sat_r;

  `DLF_ASSERT_NEXT(a_row_start, row_start, state_r == S_BIAS && j_r == '0)
  `DLF_ASSERT_SAME(a_mac_in_row, mac_busy, state_r == S_MAC || state_r == S_DRAIN)
  `DLF_ASSERT_SAME(a_last_index, out_valid_r && out_last_r, {1'b0, out_index_r} == n_out - CNT_W'(1))

endmodule
